// ----- rtl/core/indexed_list_move_engine_macros.svh -----
// Assertion macros shared by the list engine RTL
`ifndef INDEXED_LIST_MOVE_ENGINE_MACROS_SVH
`define INDEXED_LIST_MOVE_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ILME_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ILME_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine assertion failed");

`endif

// ----- rtl/core/ilme_pkg.sv -----
// Types and constants of the indexed list move engine
package ilme_pkg;

  localparam int NODE_W     = 10;
  localparam int LINK_DEPTH = 2 ** NODE_W;

  typedef logic [NODE_W-1:0] node_t;

  // Largest item count that init builds
  localparam node_t MAX_ITEMS = node_t'(1022);
  localparam node_t CFG_RESET = node_t'(8);

  typedef enum logic [1:0] {
    CMD_INIT   = 2'd0,
    CMD_BEFORE = 2'd1,
    CMD_AFTER  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic  we;
    node_t waddr;
    node_t wdata;
    node_t raddr;
  } ram_req_t;

  typedef struct packed {
    node_t next_node;
    node_t prev_node;
    logic  error;
  } res_t;

endpackage

// ----- rtl/core/ilme_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module ilme_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ilme_seq.sv -----
// Command sequencer: read-modify-write of the successor and predecessor link memories
module ilme_seq
  import ilme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic [1:0] in_command,
  input  node_t    in_move_node,
  input  node_t    in_dest_node,
  input  node_t    num_items,
  input  logic     slot_free,
  output ram_req_t succ_req,
  output ram_req_t pred_req,
  input  node_t    succ_q,
  input  node_t    pred_q,
  output logic     res_load,
  output res_t     res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_QRD,
    ST_UNLINK,
    ST_LINK1,
    ST_LINK2,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  node_t  len_r, len_nxt;
  node_t  idx_r, idx_nxt;
  cmd_t   cmd_r, cmd_nxt;
  node_t  mv_r, mv_nxt;
  node_t  dst_r, dst_nxt;
  logic   fwd_hit_r, fwd_hit_nxt;
  node_t  fwd_val_r, fwd_val_nxt;
  node_t  l2_r, l2_nxt;
  node_t  r2_r, r2_nxt;
  res_t   res_r, res_nxt;

  logic          accept_slot;
  logic          take;
  cmd_t          in_cmd;
  logic [NODE_W:0] len_p1;
  logic [NODE_W:0] idx_ext;
  logic          idx_last;
  logic          bad_move;
  node_t         clamp_len;
  node_t         dval;
  node_t         l2_c;
  node_t         r2_c;

  assign in_cmd      = cmd_t'(in_command);
  assign accept_slot = (state_r == ST_IDLE) || ((state_r == ST_EMIT) && slot_free);
  assign take        = accept_slot && in_valid;
  assign in_stall    = !accept_slot;
  assign len_p1      = {1'b0, len_r} + {{NODE_W{1'b0}}, 1'b1};
  assign idx_ext     = {1'b0, idx_r};
  assign idx_last    = (idx_ext == len_p1);
  assign clamp_len   = (num_items > MAX_ITEMS) ? MAX_ITEMS : num_items;
  assign bad_move    = (in_move_node == '0) || (in_move_node > len_r) ||
                       (in_dest_node == '0) || (in_dest_node > len_r);
  assign res         = res_r;

  // Destination neighbour read in the unlink cycle, with the unlink write forwarded
  assign dval = fwd_hit_r ? fwd_val_r : ((cmd_r == CMD_BEFORE) ? pred_q : succ_q);
  assign l2_c = (cmd_r == CMD_BEFORE) ? dval : dst_r;
  assign r2_c = (cmd_r == CMD_BEFORE) ? dst_r : dval;

  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    cmd_nxt     = cmd_r;
    mv_nxt      = mv_r;
    dst_nxt     = dst_r;
    fwd_hit_nxt = fwd_hit_r;
    fwd_val_nxt = fwd_val_r;
    l2_nxt      = l2_r;
    r2_nxt      = r2_r;
    res_nxt     = res_r;
    res_load    = 1'b0;
    succ_req    = '0;
    pred_req    = '0;
    succ_req.raddr = in_move_node;
    pred_req.raddr = in_move_node;

    unique case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_INIT: begin
        // One node per cycle; the tail sentinel points at itself
        succ_req.we    = 1'b1;
        succ_req.waddr = idx_r;
        succ_req.wdata = idx_last ? idx_r : idx_r + node_t'(1);
        pred_req.we    = 1'b1;
        pred_req.waddr = idx_r;
        pred_req.wdata = (idx_r == '0) ? '0 : idx_r - node_t'(1);
        if (idx_last) begin
          res_nxt   = '{next_node: node_t'(1), prev_node: '0, error: 1'b0};
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r + node_t'(1);
        end
      end
      ST_QRD: begin
        res_nxt   = '{next_node: succ_q, prev_node: pred_q, error: 1'b0};
        state_nxt = ST_EMIT;
      end
      ST_UNLINK: begin
        // Join the old neighbours, then look up the destination side
        succ_req.we    = 1'b1;
        succ_req.waddr = pred_q;
        succ_req.wdata = succ_q;
        pred_req.we    = 1'b1;
        pred_req.waddr = succ_q;
        pred_req.wdata = pred_q;
        if (cmd_r == CMD_BEFORE) begin
          pred_req.raddr = dst_r;
          fwd_hit_nxt    = (succ_q == dst_r);
          fwd_val_nxt    = pred_q;
        end else begin
          succ_req.raddr = dst_r;
          fwd_hit_nxt    = (pred_q == dst_r);
          fwd_val_nxt    = succ_q;
        end
        state_nxt = ST_LINK1;
      end
      ST_LINK1: begin
        succ_req.we    = 1'b1;
        succ_req.waddr = l2_c;
        succ_req.wdata = mv_r;
        pred_req.we    = 1'b1;
        pred_req.waddr = r2_c;
        pred_req.wdata = mv_r;
        l2_nxt         = l2_c;
        r2_nxt         = r2_c;
        state_nxt      = ST_LINK2;
      end
      ST_LINK2: begin
        succ_req.we    = 1'b1;
        succ_req.waddr = mv_r;
        succ_req.wdata = r2_r;
        pred_req.we    = 1'b1;
        pred_req.waddr = mv_r;
        pred_req.wdata = l2_r;
        res_nxt        = '{next_node: r2_r, prev_node: l2_r, error: 1'b0};
        state_nxt      = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Dispatch a new transfer; its first link read issues this cycle
    if (take) begin
      cmd_nxt = in_cmd;
      mv_nxt  = in_move_node;
      dst_nxt = in_dest_node;
      unique case (in_cmd)
        CMD_INIT: begin
          len_nxt   = clamp_len;
          idx_nxt   = '0;
          state_nxt = ST_INIT;
        end
        CMD_QUERY: begin
          if ({1'b0, in_move_node} > len_p1) begin
            res_nxt   = '{next_node: '0, prev_node: '0, error: 1'b1};
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_QRD;
          end
        end
        CMD_BEFORE, CMD_AFTER: begin
          if (bad_move) begin
            res_nxt   = '{next_node: '0, prev_node: '0, error: 1'b1};
            state_nxt = ST_EMIT;
          end else if (in_move_node == in_dest_node) begin
            state_nxt = ST_QRD;
          end else begin
            state_nxt = ST_UNLINK;
          end
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    mv_r      <= mv_nxt;
    dst_r     <= dst_nxt;
    fwd_hit_r <= fwd_hit_nxt;
    fwd_val_r <= fwd_val_nxt;
    l2_r      <= l2_nxt;
    r2_r      <= r2_nxt;
    res_r     <= res_nxt;
  end

`include "indexed_list_move_engine_macros.svh"

  `ILME_ASSERT_IMP(a_no_write_when_free, accept_slot || state_r == ST_IDLE, !succ_req.we && !pred_req.we)
  `ILME_ASSERT_IMP(a_init_in_bounds, state_r == ST_INIT, idx_ext <= len_p1)
  `ILME_ASSERT_IMP(a_relink_skips_moved, state_r == ST_LINK1, succ_req.waddr != mv_r && pred_req.waddr != mv_r)
  `ILME_ASSERT_NXT(a_result_waits_slot, res_load, state_r == ST_IDLE || state_r == ST_QRD || state_r == ST_INIT || state_r == ST_UNLINK || state_r == ST_EMIT)

endmodule

// ----- rtl/core/indexed_list_move_engine.sv -----
// Indexed list move engine: ordered item list held as links in two memories
//
// Input channel (in_valid / in_stall): one command per transfer. Init rebuilds
// the order 1..num_items, move-before and move-after relink an item next to a
// destination item, query returns a node's neighbours (node 0 is the head).
// Result channel (out_valid / out_stall): exactly one result per command, in
// order, giving next_node, prev_node and an error flag for bad node indexes.
// Configuration (cfg_valid / cfg_ready): writes num_items; write only while
// the engine is idle. cfg_ready is always high.
// Sequence: a move steps through the unlink, relink and own-links states, set by
// the single write port of each link memory, then the result state. Query and
// a move onto itself read the links and then reach the result state, an index
// error goes straight to it, and init writes the clamped list one node per cycle.
// The result register frees the engine to accept the next command while a
// result waits; if the receiver stalls, the next result holds in the engine
// and further commands stall. Reset empties the result register, sets
// num_items to 8 and the list length to 0; the link memories are not cleared,
// so issue init before any move or query.
module indexed_list_move_engine
  import ilme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [9:0] in_move_node,
  input  logic [9:0] in_dest_node,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] out_next_node,
  output logic [9:0] out_prev_node,
  output logic       out_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_num_items
);

  node_t    num_items_r;
  logic     out_valid_r;
  res_t     out_res_r;
  logic     slot_free;
  logic     res_load;
  res_t     res;
  ram_req_t succ_req;
  ram_req_t pred_req;
  node_t    succ_q;
  node_t    pred_q;

  assign cfg_ready     = 1'b1;
  assign slot_free     = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_next_node = out_res_r.next_node;
  assign out_prev_node = out_res_r.prev_node;
  assign out_error     = out_res_r.error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_items_r <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_items_r <= cfg_num_items;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_load) begin
      out_res_r <= res;
    end
  end

  ilme_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_move_node (in_move_node),
    .in_dest_node (in_dest_node),
    .num_items    (num_items_r),
    .slot_free    (slot_free),
    .succ_req     (succ_req),
    .pred_req     (pred_req),
    .succ_q       (succ_q),
    .pred_q       (pred_q),
    .res_load     (res_load),
    .res          (res)
  );

  ilme_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_succ_ram (
    .clk   (clk),
    .we    (succ_req.we),
    .waddr (succ_req.waddr),
    .wdata (succ_req.wdata),
    .raddr (succ_req.raddr),
    .rdata (succ_q)
  );

  ilme_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_pred_ram (
    .clk   (clk),
    .we    (pred_req.we),
    .waddr (pred_req.waddr),
    .wdata (pred_req.wdata),
    .raddr (pred_req.raddr),
    .rdata (pred_q)
  );

endmodule

// ----- test/tb_indexed_list_move_engine.sv -----
// Testbench for the indexed list move engine: random commands checked against a link predictor
`timescale 1ns / 1ps

import ilme_pkg::*;

class link_tracker;
  node_t       succ_of [LINK_DEPTH];
  node_t       pred_of [LINK_DEPTH];
  int unsigned list_len;
  node_t       item_count;
  res_t        pending [$];
  int unsigned errors;
  int unsigned inits, moves, self_moves, queries, bad_index;

  function new();
    list_len   = 0;
    item_count = CFG_RESET;
  endfunction

  function void set_count(node_t v);
    item_count = v;
  endfunction

  // Work out the one result a command causes and queue it
  function void note_command(cmd_t c, node_t mv, node_t dst);
    res_t        r;
    int unsigned n, i, l, rt;
    r = '0;
    n = list_len;
    case (c)
      CMD_INIT: begin
        n = (item_count > MAX_ITEMS) ? MAX_ITEMS : item_count;
        list_len = n;
        for (i = 0; i <= n; i++) begin
          succ_of[i]   = node_t'(i + 1);
          pred_of[i+1] = node_t'(i);
        end
        pred_of[0]   = '0;
        succ_of[n+1] = node_t'(n + 1);
        r.next_node  = succ_of[0];
        r.prev_node  = pred_of[0];
        inits++;
      end
      CMD_QUERY: begin
        queries++;
        if (mv > n + 1) begin
          r.error = 1'b1;
          bad_index++;
        end else begin
          r.next_node = succ_of[mv];
          r.prev_node = pred_of[mv];
        end
      end
      default: begin
        moves++;
        if (mv < 1 || mv > n || dst < 1 || dst > n) begin
          r.error = 1'b1;
          bad_index++;
        end else begin
          if (mv != dst) begin
            // unlink first, then read the destination's neighbours afresh
            l = pred_of[mv];
            rt = succ_of[mv];
            succ_of[l]  = node_t'(rt);
            pred_of[rt] = node_t'(l);
            if (c == CMD_BEFORE) begin
              l  = pred_of[dst];
              rt = dst;
            end else begin
              l  = dst;
              rt = succ_of[dst];
            end
            succ_of[l]  = mv;
            pred_of[rt] = mv;
            pred_of[mv] = node_t'(l);
            succ_of[mv] = node_t'(rt);
          end else begin
            self_moves++;
          end
          r.next_node = succ_of[mv];
          r.prev_node = pred_of[mv];
        end
      end
    endcase
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(node_t nx, node_t pv, logic err);
    res_t want;
    if (pending.size() == 0) begin
      $error("result with nothing expected: next_node %0d prev_node %0d error %0b",
             nx, pv, err);
      errors++;
    end else begin
      want = pending.pop_front();
      if (nx !== want.next_node) begin
        $error("next_node: expected %0d, actual %0d", want.next_node, nx);
        errors++;
      end
      if (pv !== want.prev_node) begin
        $error("prev_node: expected %0d, actual %0d", want.prev_node, pv);
        errors++;
      end
      if (err !== want.error) begin
        $error("error: expected %0b, actual %0b", want.error, err);
        errors++;
      end
    end
  endfunction
endclass

module tb_indexed_list_move_engine;

  localparam int unsigned RUN_LIMIT   = 400000;
  localparam int unsigned SETTLE      = 1040;
  localparam int unsigned HOLD_CYCLES = 300;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [1:0] in_command    = '0;
  logic [9:0] in_move_node  = '0;
  logic [9:0] in_dest_node  = '0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [9:0] out_next_node;
  logic [9:0] out_prev_node;
  logic       out_error;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_num_items = '0;

  link_tracker tracker;
  bit          steady         = 1'b0;
  bit          hold_off_start = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  indexed_list_move_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_move_node  (in_move_node),
    .in_dest_node  (in_dest_node),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_node (out_next_node),
    .out_prev_node (out_prev_node),
    .out_error     (out_error),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_num_items (cfg_num_items)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_next_node, out_prev_node, out_error);
    if (hold_off_start) begin
      hold_left = HOLD_CYCLES;
      hold_off_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 21);
    end
  end

  task automatic send_command(input cmd_t c, input node_t mv, input node_t dst);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= c;
    in_move_node <= mv;
    in_dest_node <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_command(c, mv, dst);
  endtask

  // Hold the input until every queued result has been seen, then let the engine settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_count(input node_t v);
    cfg_valid     <= 1'b1;
    cfg_num_items <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_count(v);
    @(posedge clk);
  endtask

  task automatic run_phase(input node_t count, input int unsigned items,
                           input bit with_pressure);
    int unsigned n, pick, k;
    node_t       mv, dst;
    drain();
    write_count(count);
    n = (count > MAX_ITEMS) ? MAX_ITEMS : count;
    send_command(CMD_INIT, node_t'($urandom), node_t'($urandom));
    for (k = 0; k < items; k++) begin
      if (with_pressure && k == 40) hold_off_start = 1'b1;
      if (with_pressure && k == 120) drain();
      if (with_pressure) steady = (k >= 200 && k < 380);
      pick = $urandom_range(0, 99);
      if (pick < 2 && (n < 64 || $urandom_range(0, 9) == 0)) begin
        send_command(CMD_INIT, node_t'($urandom), node_t'($urandom));
      end else if (pick < 55 && n > 0) begin
        mv  = node_t'($urandom_range(1, n));
        dst = ($urandom_range(0, 19) == 0) ? mv : node_t'($urandom_range(1, n));
        send_command($urandom_range(0, 1) ? CMD_BEFORE : CMD_AFTER, mv, dst);
      end else if (pick < 80) begin
        send_command(CMD_QUERY, node_t'($urandom_range(0, n + 1)), node_t'($urandom));
      end else begin
        // noise: any command, indexes across the whole field
        send_command(cmd_t'($urandom_range(0, 3)), node_t'($urandom_range(0, 1023)),
                     node_t'($urandom_range(0, 1023)));
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no list built yet: moves are bad indexes, so is a query above node 1
    send_command(CMD_BEFORE, 10'd1, 10'd2);
    send_command(CMD_QUERY, 10'd1023, 10'd0);
    send_command(CMD_INIT, 10'd0, 10'd1023);
    send_command(CMD_QUERY, 10'd0, 10'd1023);
    send_command(CMD_QUERY, 10'd9, 10'd0);
    send_command(CMD_QUERY, 10'd10, 10'd0);
    send_command(CMD_BEFORE, 10'd3, 10'd1);
    send_command(CMD_AFTER, 10'd5, 10'd8);
    send_command(CMD_AFTER, 10'd1, 10'd3);
    send_command(CMD_BEFORE, 10'd8, 10'd5);
    send_command(CMD_AFTER, 10'd2, 10'd2);
    send_command(CMD_BEFORE, 10'd4, 10'd4);
    send_command(CMD_BEFORE, 10'd6, 10'd0);
    send_command(CMD_AFTER, 10'd6, 10'd9);
    send_command(CMD_AFTER, 10'd0, 10'd6);
    send_command(CMD_BEFORE, 10'd1023, 10'd1023);
    send_command(CMD_BEFORE, 10'd512, 10'd3);
    send_command(CMD_QUERY, 10'd0, 10'd0);
    send_command(CMD_QUERY, 10'd3, 10'd682);
    send_command(CMD_QUERY, 10'd5, 10'd341);
    send_command(CMD_AFTER, 10'd7, 10'd1);
    send_command(CMD_QUERY, 10'd9, 10'd0);

    run_phase(10'd0, 30, 1'b0);
    run_phase(10'd1, 40, 1'b0);
    run_phase(10'd2, 60, 1'b0);
    run_phase(10'd1022, 60, 1'b0);
    run_phase(10'd1023, 40, 1'b0);
    run_phase(node_t'($urandom_range(3, 40)), 500, 1'b1);
    run_phase(node_t'($urandom_range(3, 40)), 300, 1'b0);
    run_phase(node_t'($urandom_range(41, 300)), 300, 1'b0);
    run_phase(10'd8, 70, 1'b0);
    drain();

    $display("covered %0d inits, %0d moves (%0d onto themselves), %0d queries, %0d bad indexes",
             tracker.inits, tracker.moves, tracker.self_moves, tracker.queries,
             tracker.bad_index);
    $display("list sizes 0, 1, 2, full, saturated and random; long result hold-off and drains");
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
